// ----- design/rflr_pkg.sv -----
// ============================================================================
// rflr_pkg
// Shared types, widths and constants of the ring FIFO linear resampler.
// ============================================================================
package rflr_pkg;

    // ring geometry
    localparam int unsigned CAPACITY = 4096;
    localparam int unsigned PTR_W    = $clog2(CAPACITY);
    localparam int unsigned FILL_W   = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);

    // field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned STEP_W   = 19;
    localparam int unsigned VOL_W    = 16;
    localparam int unsigned PHASE_W  = 16;
    localparam int unsigned METER_W  = 16;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned CFG_W    = 19;

    // shared multiplier operand and product widths
    localparam int unsigned MUL_W  = 18;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // reset values of the configuration registers
    localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(65536);
    localparam logic [VOL_W-1:0]  VOLUME_RESET = VOL_W'(32768);

    // meter decay factors in Q0.15, and the meter ceiling
    localparam logic [MUL_W-1:0]   DECAY_PUSH   = MUL_W'(19661);
    localparam logic [MUL_W-1:0]   DECAY_RENDER = MUL_W'(29491);
    localparam logic [METER_W:0]   METER_MAX    = (METER_W + 1)'(32768);

    // request codes carried in tuser
    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_RENDER = 2'd1,
        REQ_FLUSH  = 2'd2
    } req_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_PHASE_STEP = 2'd0,
        CFG_VOLUME     = 2'd1,
        CFG_MUTE       = 2'd2
    } cfg_reg_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_GAIN,
        ST_DECAY,
        ST_METER,
        ST_FINISH
    } state_t;

    // write request into the sample ring
    typedef struct packed {
        logic                en;
        logic [PTR_W-1:0]    addr;
        logic [SAMPLE_W-1:0] data;
    } ring_wr_t;

endpackage

// ----- design/ring_fifo_linear_resampler.sv -----
// ============================================================================
// ring_fifo_linear_resampler
// Audio ring FIFO with a linear-interpolation rate converter and peak meter.
// ============================================================================
// Items arrive on the s_axis channel: tuser selects push, render or flush and
// carries the block start flag, tdata carries the sample for a push. Each
// item gives exactly one result on m_axis: the rendered sample, the peak
// meter, the fill count and (in tuser) the underrun flag.
// A push writes the ring and updates the meter; a render reads the two
// oldest samples, interpolates at the read phase, applies the gain and
// advances the phase; a flush empties the buffer.
// One item is worked on at a time by a small sequencer around one shared
// multiplier and a single-read-port sample RAM, so s_axis_tready is high
// only while the sequencer is idle. A render makes two serial RAM reads,
// then the interpolation and gain products; a push or an underrun render
// makes the meter decay product; a flush goes straight to the result.
// The result sits in an output register; while m_axis_tready is low the
// finished result holds and the next result waits in the sequencer.
// Registers are written on the cfg channel (always ready); the user must
// write them only while idle, the block itself does not enforce it.
// Reset empties the buffer, clears the meter and loads the register
// defaults: phase step 1.0, volume unity, mute off. No clearing pass.
// ============================================================================
module ring_fifo_linear_resampler (
    input  logic                             clk,
    input  logic                             rst_n,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,  // [15:0] sample
    input  logic [2:0]                       s_axis_tuser,  // [1:0] req_type, [2] block_start
    // results
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // [15:0] out_sample,
                                                            // [31:16] peak_level,
                                                            // [44:32] fill_count
    output logic                             m_axis_tuser,  // [0] underrun
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [1:0]                       cfg_index,
    input  logic [rflr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int unsigned PW = rflr_pkg::PTR_W;
    localparam int unsigned FW = rflr_pkg::FILL_W;
    localparam int unsigned SUM_W = (FW > 5) ? FW : 5;

    // control state
    rflr_pkg::state_t                   state_reg, state_next;
    logic [PW-1:0]                      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                      rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]                      fill_reg, fill_next;
    logic [rflr_pkg::PHASE_W-1:0]       phase_reg, phase_next;
    logic [rflr_pkg::METER_W-1:0]       meter_reg, meter_next;
    logic [rflr_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [rflr_pkg::VOL_W-1:0]         volume_reg, volume_next;
    logic                               mute_reg, mute_next;
    logic                               out_valid_reg, out_valid_next;

    // item and result payload
    logic [1:0]                         req_reg, req_next;
    logic [rflr_pkg::SAMPLE_W-1:0]      sample_reg, sample_next;
    logic                               start_reg, start_next;
    logic [rflr_pkg::SAMPLE_W-1:0]      s0_reg, s0_next;
    logic [rflr_pkg::SAMPLE_W-1:0]      y_reg, y_next;
    logic                               under_reg, under_next;
    logic [47:0]                        out_data_reg, out_data_next;
    logic                               out_user_reg, out_user_next;

    // shared units
    rflr_pkg::ring_wr_t                 ring_wr;
    logic [PW-1:0]                      ring_raddr;
    logic [rflr_pkg::SAMPLE_W-1:0]      ring_rdata;
    logic signed [rflr_pkg::MUL_W-1:0]  mul_a;
    logic signed [rflr_pkg::MUL_W-1:0]  mul_b;
    logic signed [rflr_pkg::PROD_W-1:0] prod;

    logic                               in_fire;

    // sign-extended difference of two samples
    function automatic logic signed [rflr_pkg::MUL_W-1:0] MUL_W_sub(
        input logic [rflr_pkg::SAMPLE_W-1:0] x,
        input logic [rflr_pkg::SAMPLE_W-1:0] y
    );
        logic signed [rflr_pkg::MUL_W-1:0] xe;
        logic signed [rflr_pkg::MUL_W-1:0] ye;
        xe = $signed({{2{x[rflr_pkg::SAMPLE_W-1]}}, x});
        ye = $signed({{2{y[rflr_pkg::SAMPLE_W-1]}}, y});
        return xe - ye;
    endfunction

    rflr_ring u_ring (
        .clk   (clk),
        .wr    (ring_wr),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    rflr_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign s_axis_tready = (state_reg == rflr_pkg::ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // sequencer: next state, datapath selects and register updates
    always_comb
    begin
        logic [PW-1:0]                  rd_inc;
        logic [PW-1:0]                  wr_inc;
        logic signed [rflr_pkg::MUL_W-1:0] interp;
        logic signed [rflr_pkg::MUL_W-1:0] scaled;
        logic [rflr_pkg::SAMPLE_W-1:0]  sat;
        logic [19:0]                    total;
        logic [SUM_W-1:0]               whole;
        logic [FW-1:0]                  consumed;
        logic [FW-1:0]                  rd_sum;
        logic [rflr_pkg::METER_W-1:0]   base;
        logic [rflr_pkg::METER_W:0]     mag;
        logic [rflr_pkg::METER_W:0]     peak;

        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        meter_next     = meter_reg;
        step_next      = step_reg;
        volume_next    = volume_reg;
        mute_next      = mute_reg;
        out_valid_next = out_valid_reg;
        req_next       = req_reg;
        sample_next    = sample_reg;
        start_next     = start_reg;
        s0_next        = s0_reg;
        y_next         = y_reg;
        under_next     = under_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        ring_wr.en   = 1'b0;
        ring_wr.addr = wr_ptr_reg;
        ring_wr.data = s_axis_tdata;
        ring_raddr   = rd_ptr_reg;
        mul_a        = '0;
        mul_b        = '0;

        rd_inc = (rd_ptr_reg == rflr_pkg::LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        wr_inc = (wr_ptr_reg == rflr_pkg::LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;

        interp = '0;
        scaled = '0;
        sat    = '0;
        total  = '0;
        whole  = '0;
        consumed = '0;
        rd_sum = '0;
        base   = '0;
        mag    = '0;
        peak   = '0;

        // result taken downstream
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                rflr_pkg::CFG_PHASE_STEP:
                begin
                    step_next   = cfg_data[rflr_pkg::STEP_W-1:0];
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    fill_next   = '0;
                    phase_next  = '0;
                end
                rflr_pkg::CFG_VOLUME:
                begin
                    volume_next = cfg_data[rflr_pkg::VOL_W-1:0];
                end
                rflr_pkg::CFG_MUTE:
                begin
                    mute_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            rflr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    req_next    = s_axis_tuser[1:0];
                    sample_next = s_axis_tdata;
                    start_next  = s_axis_tuser[2];
                    y_next      = '0;
                    under_next  = 1'b0;
                    case (s_axis_tuser[1:0])
                        rflr_pkg::REQ_PUSH:
                        begin
                            // store and advance, overwriting the oldest when full
                            ring_wr.en  = 1'b1;
                            wr_ptr_next = wr_inc;
                            if (fill_reg < FW'(rflr_pkg::CAPACITY))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                            begin
                                rd_ptr_next = rd_inc;
                            end
                            state_next = rflr_pkg::ST_DECAY;
                        end
                        rflr_pkg::REQ_RENDER:
                        begin
                            if (fill_reg < FW'(2))
                            begin
                                under_next = 1'b1;
                                state_next = rflr_pkg::ST_DECAY;
                            end
                            else
                            begin
                                // ring read of the oldest sample is under way
                                state_next = rflr_pkg::ST_RD0;
                            end
                        end
                        rflr_pkg::REQ_FLUSH:
                        begin
                            wr_ptr_next = '0;
                            rd_ptr_next = '0;
                            fill_next   = '0;
                            phase_next  = '0;
                            state_next  = rflr_pkg::ST_FINISH;
                        end
                        default:
                        begin
                            state_next = rflr_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            rflr_pkg::ST_RD0:
            begin
                // oldest sample in, fetch the next one
                s0_next    = ring_rdata;
                ring_raddr = rd_inc;
                state_next = rflr_pkg::ST_RD1;
            end

            rflr_pkg::ST_RD1:
            begin
                // (s1 - s0) * phase
                mul_a = MUL_W_sub(ring_rdata, s0_reg);
                mul_b = $signed({2'b00, phase_reg});
                state_next = rflr_pkg::ST_INTERP;
            end

            rflr_pkg::ST_INTERP:
            begin
                // s0 + floor(product / 2^16), then times volume
                interp = $signed({{2{s0_reg[rflr_pkg::SAMPLE_W-1]}}, s0_reg})
                       + prod[33:16];
                mul_a = interp;
                mul_b = $signed({2'b00, volume_reg});
                state_next = rflr_pkg::ST_GAIN;
            end

            rflr_pkg::ST_GAIN:
            begin
                // floor(product / 2^15), saturated, or zero when muted
                scaled = prod[32:15];
                if (scaled > $signed(rflr_pkg::MUL_W'(32767)))
                begin
                    sat = 16'h7FFF;
                end
                else if (scaled < -$signed(rflr_pkg::MUL_W'(32768)))
                begin
                    sat = 16'h8000;
                end
                else
                begin
                    sat = scaled[rflr_pkg::SAMPLE_W-1:0];
                end
                y_next = mute_reg ? '0 : sat;

                // phase advance consumes at most the buffered samples
                total = {4'b0000, phase_reg} + {1'b0, step_reg};
                whole = SUM_W'(total[19:16]);
                if (whole > SUM_W'(fill_reg))
                begin
                    consumed = fill_reg;
                end
                else
                begin
                    consumed = FW'(whole);
                end
                rd_sum = FW'(rd_ptr_reg) + consumed;
                if (rd_sum >= FW'(rflr_pkg::CAPACITY))
                begin
                    rd_sum = rd_sum - FW'(rflr_pkg::CAPACITY);
                end
                rd_ptr_next = rd_sum[PW-1:0];
                fill_next   = fill_reg - consumed;
                phase_next  = total[15:0];
                state_next  = rflr_pkg::ST_FINISH;
            end

            rflr_pkg::ST_DECAY:
            begin
                // meter times the decay factor of this request
                mul_a = $signed({2'b00, meter_reg});
                mul_b = (req_reg == rflr_pkg::REQ_PUSH) ? $signed(rflr_pkg::DECAY_PUSH)
                                                        : $signed(rflr_pkg::DECAY_RENDER);
                state_next = rflr_pkg::ST_METER;
            end

            rflr_pkg::ST_METER:
            begin
                base = start_reg ? prod[30:15] : meter_reg;
                if (req_reg == rflr_pkg::REQ_PUSH)
                begin
                    // magnitude of the pushed sample, then peak hold and clamp
                    if (sample_reg[rflr_pkg::SAMPLE_W-1])
                    begin
                        mag = (rflr_pkg::METER_W + 1)'(0) - {1'b1, sample_reg};
                    end
                    else
                    begin
                        mag = {1'b0, sample_reg};
                    end
                    peak = (mag > {1'b0, base}) ? mag : {1'b0, base};
                    if (peak > rflr_pkg::METER_MAX)
                    begin
                        peak = rflr_pkg::METER_MAX;
                    end
                    meter_next = peak[rflr_pkg::METER_W-1:0];
                end
                else
                begin
                    meter_next = base;
                end
                state_next = rflr_pkg::ST_FINISH;
            end

            rflr_pkg::ST_FINISH:
            begin
                // load the output register once it is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000,
                                      rflr_pkg::COUNT_W'(fill_reg),
                                      meter_reg,
                                      y_reg};
                    out_user_next  = under_reg;
                    state_next     = rflr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rflr_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rflr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // buffer, meter and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            meter_reg     <= '0;
            step_reg      <= rflr_pkg::STEP_RESET;
            volume_reg    <= rflr_pkg::VOLUME_RESET;
            mute_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            meter_reg     <= meter_next;
            step_reg      <= step_next;
            volume_reg    <= volume_next;
            mute_reg      <= mute_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        sample_reg   <= sample_next;
        start_reg    <= start_next;
        s0_reg       <= s0_next;
        y_reg        <= y_next;
        under_reg    <= under_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

endmodule

// ----- design/rflr_ring.sv -----
// ============================================================================
// rflr_ring
// Sample ring storage: one write port, one registered read port.
// ============================================================================
module rflr_ring (
    input  logic                              clk,
    input  rflr_pkg::ring_wr_t                wr,
    input  logic [rflr_pkg::PTR_W-1:0]        raddr,
    output logic [rflr_pkg::SAMPLE_W-1:0]     rdata
);

    logic [rflr_pkg::SAMPLE_W-1:0] mem [rflr_pkg::CAPACITY];
    logic [rflr_pkg::SAMPLE_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/rflr_mul.sv -----
// ============================================================================
// rflr_mul
// Shared signed multiplier with a registered product.
// ============================================================================
module rflr_mul (
    input  logic                                 clk,
    input  logic signed [rflr_pkg::MUL_W-1:0]    mul_a,
    input  logic signed [rflr_pkg::MUL_W-1:0]    mul_b,
    output logic signed [rflr_pkg::PROD_W-1:0]   prod
);

    logic signed [rflr_pkg::PROD_W-1:0] prod_reg;

    // one product per cycle, used by interpolation, gain and meter decay
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// ----- sim/resampler_result_check.sv -----
`timescale 1ns / 100ps
// ============================================================================
// resampler_result_check
// Watches the item, result and register channels of the ring FIFO
// resampler, keeps its own copy of the buffer, phase, meter and registers,
// and compares every result with the oldest predicted one, field by field.
// ============================================================================
module resampler_result_check
    import rflr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,
    input  logic [2:0]         s_axis_tuser,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [47:0]        m_axis_tdata,
    input  logic               m_axis_tuser,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output int                 error_count,
    output int                 pending_count
);

    typedef struct {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic [METER_W-1:0]         peak_level;
        logic [COUNT_W-1:0]         fill_count;
        logic                       underrun;
    } resampler_out_t;

    // shadow of the block state
    logic signed [SAMPLE_W-1:0] ring_copy [CAPACITY];
    int unsigned wr_ptr     = 0;
    int unsigned rd_ptr     = 0;
    int unsigned fill       = 0;
    int unsigned phase      = 0;
    int unsigned meter      = 0;
    int unsigned step_reg   = 65536;
    int unsigned volume_reg = 32768;
    logic        mute_reg   = 1'b0;
    int          mismatches = 0;

    resampler_out_t pending_outputs [$];

    assign error_count = mismatches;

    // advance the shadow state by one item and return the result it gives
    function automatic resampler_out_t resample_step(input logic [1:0] req,
                                                     input logic signed [15:0] smp,
                                                     input logic start);
        resampler_out_t r;
        int          sval;
        int unsigned mag;
        longint      s0;
        longint      s1;
        longint      interp;
        longint      gained;
        int unsigned total;
        int unsigned whole;
        r.out_sample = '0;
        r.underrun   = 1'b0;
        case (req)
            REQ_PUSH:
            begin
                sval = smp;
                mag  = (sval < 0) ? -sval : sval;
                if (start)
                    meter = (meter * 19661) >> 15;
                if (mag > meter)
                    meter = mag;
                if (meter > 32768)
                    meter = 32768;
                ring_copy[wr_ptr] = smp;
                wr_ptr = (wr_ptr + 1) % CAPACITY;
                if (fill < CAPACITY)
                    fill++;
                else
                    rd_ptr = (rd_ptr + 1) % CAPACITY;
            end
            REQ_RENDER:
            begin
                if (fill < 2)
                begin
                    r.underrun = 1'b1;
                    if (start)
                        meter = (meter * 29491) >> 15;
                end
                else
                begin
                    s0     = ring_copy[rd_ptr];
                    s1     = ring_copy[(rd_ptr + 1) % CAPACITY];
                    interp = s0 + (((s1 - s0) * longint'(phase)) >>> 16);
                    gained = mute_reg ? 64'sd0 : ((interp * longint'(volume_reg)) >>> 15);
                    if (gained > 32767)
                        gained = 32767;
                    if (gained < -32768)
                        gained = -32768;
                    r.out_sample = gained[15:0];
                    // consume whole samples, drop what cannot be consumed
                    total = phase + step_reg;
                    whole = total >> 16;
                    if (whole > fill)
                        whole = fill;
                    rd_ptr = (rd_ptr + whole) % CAPACITY;
                    fill   = fill - whole;
                    phase  = total & 16'hFFFF;
                end
            end
            REQ_FLUSH:
            begin
                wr_ptr = 0;
                rd_ptr = 0;
                fill   = 0;
                phase  = 0;
            end
            default:
            begin
            end
        endcase
        r.peak_level = meter[15:0];
        r.fill_count = fill[12:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        resampler_out_t want;
        if (!rst_n)
        begin
            wr_ptr     = 0;
            rd_ptr     = 0;
            fill       = 0;
            phase      = 0;
            meter      = 0;
            step_reg   = 65536;
            volume_reg = 32768;
            mute_reg   = 1'b0;
            pending_outputs.delete();
            pending_count <= 0;
        end
        else
        begin
            // compare an accepted result with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $error("unexpected result: out_sample %0d with nothing pending",
                           $signed(m_axis_tdata[15:0]));
                    mismatches++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (m_axis_tdata[15:0] !== want.out_sample)
                    begin
                        $error("out_sample: expected %0d, got %0d",
                               want.out_sample, $signed(m_axis_tdata[15:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[31:16] !== want.peak_level)
                    begin
                        $error("peak_level: expected %0d, got %0d",
                               want.peak_level, m_axis_tdata[31:16]);
                        mismatches++;
                    end
                    if (m_axis_tdata[44:32] !== want.fill_count)
                    begin
                        $error("fill_count: expected %0d, got %0d",
                               want.fill_count, m_axis_tdata[44:32]);
                        mismatches++;
                    end
                    if (m_axis_tuser !== want.underrun)
                    begin
                        $error("underrun: expected %0d, got %0d",
                               want.underrun, m_axis_tuser);
                        mismatches++;
                    end
                end
            end

            // register writes, a step write also empties the buffer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PHASE_STEP:
                    begin
                        step_reg = cfg_data[STEP_W-1:0];
                        wr_ptr   = 0;
                        rd_ptr   = 0;
                        fill     = 0;
                        phase    = 0;
                    end
                    CFG_VOLUME:
                        volume_reg = cfg_data[VOL_W-1:0];
                    CFG_MUTE:
                        mute_reg = cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            // predict the result of an accepted request
            if (s_axis_tvalid && s_axis_tready)
                pending_outputs.push_back(resample_step(s_axis_tuser[1:0], s_axis_tdata,
                                                        s_axis_tuser[2]));

            pending_count <= pending_outputs.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Testbench of the ring FIFO linear resampler: directed and random push,
// render and flush traffic under several register settings and idling
// mixes; a separate result checker predicts and compares every result.
// ============================================================================
module tb_top;
    import rflr_pkg::*;

    localparam int         QUIET_LIMIT = 4000;
    localparam int         SETTLE      = 10;
    localparam int         PHASE_ITEMS = 160;
    localparam logic [1:0] REQ_SPARE   = 2'd3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata;
    logic [2:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [47:0]        m_axis_tdata;
    logic               m_axis_tuser;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    int error_count;
    int pending_count;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int quiet_cycles    = 0;

    ring_fifo_linear_resampler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    resampler_result_check i_result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 100 MHz clock, low first so the first rising edge comes after setup
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result sink with random back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // watchdog on cycles without any accepted request
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // one item on s_axis, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] req, input logic [15:0] smp,
                                input logic start);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= {start, req};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // hold off until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly uniform samples, now and then a full-scale, zero or minus-one one
    function automatic logic [15:0] rand_sample();
        logic [15:0] corners [4];
        corners = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
        if ($urandom_range(7) == 0)
            return corners[$urandom_range(3)];
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic push_block(input int len);
        for (int k = 0; k < len; k++)
            send_request(REQ_PUSH, rand_sample(), k == 0);
    endtask

    task automatic render_block(input int len);
        for (int k = 0; k < len; k++)
            send_request(REQ_RENDER, 16'($urandom_range(16'hFFFF)), k == 0);
    endtask

    // push and render blocks with random content, some flushes and noise
    task automatic run_traffic(input int count);
        int done;
        int pick;
        int len;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            len  = $urandom_range(1, 12);
            if (pick < 48)
                push_block(len);
            else if (pick < 92)
                render_block(len);
            else if (pick < 95)
            begin
                send_request(REQ_FLUSH, rand_sample(), 1'($urandom_range(1)));
                len = 1;
            end
            else if (pick < 97)
            begin
                send_request(REQ_SPARE, rand_sample(), 1'($urandom_range(1)));
                len = 1;
            end
            else
            begin
                send_request(2'($urandom_range(3)), rand_sample(), 1'($urandom_range(1)));
                len = 1;
            end
            done += len;
            if ($urandom_range(40) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        int unsigned step_tab [8];
        int unsigned vol_tab  [8];
        logic        mute_tab [8];
        int          idle_tab [4];
        int          stall_tab [4];

        step_tab  = '{65536, 1, 524287, 0, 98304, 0, 32768, 0};
        vol_tab   = '{32768, 65535, 0, 32768, 49152, 0, 65535, 0};
        mute_tab  = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        idle_tab  = '{0, 61, 0, 23};
        stall_tab = '{0, 0, 61, 23};

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default registers, underrun, meter clamp and decays
        send_request(REQ_RENDER, 16'h0000, 1'b1);
        send_request(REQ_PUSH,   16'h7FFF, 1'b1);
        send_request(REQ_PUSH,   16'h8000, 1'b0);
        send_request(REQ_RENDER, 16'hFFFF, 1'b0);
        send_request(REQ_RENDER, 16'h0000, 1'b1);
        send_request(REQ_PUSH,   16'h0000, 1'b1);
        send_request(REQ_PUSH,   16'hFFFF, 1'b0);
        send_request(REQ_PUSH,   16'h0001, 1'b0);
        send_request(REQ_RENDER, 16'h0000, 1'b1);
        send_request(REQ_RENDER, 16'h0000, 1'b0);
        send_request(REQ_SPARE,  16'h5555, 1'b1);
        send_request(REQ_FLUSH,  16'hAAAA, 1'b1);
        send_request(REQ_PUSH,   16'h1234, 1'b0);
        send_request(REQ_RENDER, 16'h0000, 1'b0);
        wait_drained();

        // directed: half step and full gain, saturation both ways
        write_reg(CFG_PHASE_STEP, 19'd32768);
        write_reg(CFG_VOLUME, 19'd65535);
        send_request(REQ_PUSH, 16'h7FFF, 1'b1);
        send_request(REQ_PUSH, 16'h8000, 1'b0);
        send_request(REQ_PUSH, 16'h7FFF, 1'b0);
        send_request(REQ_PUSH, 16'h8000, 1'b0);
        send_request(REQ_PUSH, 16'h0000, 1'b0);
        render_block(5);
        wait_drained();

        // random phases over register settings and idling mixes
        for (int p = 0; p < 8; p++)
        begin
            if (p == 5)
                step_tab[p] = $urandom_range(16384, 131072);
            if (p == 7)
                step_tab[p] = $urandom_range(524287);
            if (p == 5 || p == 7)
                vol_tab[p] = $urandom_range(65535);
            if (p == 7)
                mute_tab[p] = 1'($urandom_range(1));
            if (p == 3)
                write_reg(CFG_SPARE, 19'($urandom_range(524287)));
            write_reg(CFG_PHASE_STEP, 19'(step_tab[p]));
            write_reg(CFG_VOLUME, 19'(vol_tab[p]));
            write_reg(CFG_MUTE, 19'(mute_tab[p]));
            sender_idle_pct = idle_tab[p % 4];
            sink_stall_pct  = stall_tab[p % 4];
            run_traffic(PHASE_ITEMS);
            wait_drained();
        end

        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/rflr_pkg.sv
design/rflr_ring.sv
design/rflr_mul.sv
design/ring_fifo_linear_resampler.sv
sim/resampler_result_check.sv
sim/tb_top.sv
